>>> rtl/sac_pkg.sv
// Shared types and constants for the set-associative cache tag block.
// Used by sac_ctrl, sac_datapath and set_assoc_cache_lru_tags; no dependencies.
`default_nettype none

package sac_pkg;

  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 1;
  localparam int BLK_W     = 32;
  localparam int TAG_W     = 32;
  localparam int AGE_W     = 4;
  localparam int CNT_W     = 32;
  localparam int WCNT_W    = 5;
  localparam int BITS_W    = 5;
  localparam int WAY_OUT_W = 3;
  localparam int SET_OUT_W = 10;
  localparam int OUT_DATA_W = 80;
  localparam int OUT_USED_W = WAY_OUT_W + SET_OUT_W + 2 * CNT_W;

  localparam logic [CFG_IDX_W-1:0] REG_SET_BITS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS     = 1'b1;

  localparam logic [CFG_W-1:0] SET_BITS_RESET = 4'd6;
  localparam logic [CFG_W-1:0] WAYS_RESET     = 4'd4;

  localparam logic [AGE_W-1:0] AGE_MAX = 4'd15;
  localparam logic [AGE_W-1:0] AGE_MRU = 4'd1;

  typedef struct packed {
    logic             valid;
    logic [AGE_W-1:0] age;
    logic [TAG_W-1:0] tag;
  } line_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } dp_status_t;

  function automatic logic [AGE_W-1:0] age_inc(input logic [AGE_W-1:0] a);
    age_inc = (a < AGE_MAX) ? a + AGE_MRU : AGE_MAX;
  endfunction

endpackage

`default_nettype wire

>>> rtl/set_assoc_cache_lru_tags.sv
// Top level of the set-associative cache tag model with true-LRU replacement.
// Instantiates sac_ctrl and sac_datapath; uses sac_pkg.
//
// The slave stream carries one memory block number per beat. The low bits select
// a set, the rest form the tag, and the block looks the tag up in every way in use of
// that set. The master stream returns one beat per input beat, in order: the
// hit flag, the way used, the set index and the running hit and miss totals.
// Configuration (set index bits, ways in use) is written through cfg_we,
// cfg_index and cfg_data while no access is in flight.
// The result beat is registered in the output register when the access is written back,
// and the block takes no new access until that write-back: the set row is read from a
// synchronous memory when the access is accepted and written back in the lookup state.
// After reset the block sweeps every row of the set memory, one row per cycle,
// with s_axis_tready low;
// configuration writes are still taken. A finished result waits in the output
// register while the next access proceeds; if the receiver stalls, the
// write-back of that next access holds until the output register is free.
`default_nettype none

module set_assoc_cache_lru_tags
  import sac_pkg::*;
#(
  parameter int MAX_SETS = 1024,
  parameter int MAX_WAYS = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // Fields from bit 0: block_number[31:0].
  input  wire logic [BLK_W-1:0]     s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // Fields from bit 0: way_used[2:0], set_selected[12:3], hits_so_far[44:13],
  // misses_so_far[76:45], zero fill[79:77].
  output logic [OUT_DATA_W-1:0]     m_axis_tdata,
  // Fields from bit 0: hit[0].
  output logic                      m_axis_tuser
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  sac_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status        (status),
    .cmd           (cmd)
  );

  sac_datapath #(
    .MAX_SETS (MAX_SETS),
    .MAX_WAYS (MAX_WAYS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

>>> rtl/sac_ctrl.sv
// Sequencing controller for the cache tag block: clearing sweep, lookup, write-back.
// Depends on sac_pkg; drives sac_datapath through command and status structs.
`default_nettype none

module sac_ctrl
  import sac_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  state_t state;

  assign s_axis_tready = (state == ST_IDLE);
  assign cmd.clear     = (state == ST_CLEAR);
  assign cmd.accept    = (state == ST_IDLE) && s_axis_tvalid;
  assign cmd.commit    = (state == ST_LOOKUP) && status.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          if (status.clear_last) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            state <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          if (status.out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/sac_datapath.sv
// Datapath for the cache tag block: set memory, tag match, LRU age update,
// hit and miss totals, configuration registers and the result register. Uses sac_pkg.
`default_nettype none

module sac_datapath
  import sac_pkg::*;
#(
  parameter int MAX_SETS = 1024,
  parameter int MAX_WAYS = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ctrl_cmd_t            cmd,
  output dp_status_t                status,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic [BLK_W-1:0]     s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                      m_axis_tuser
);

  localparam int IDX_MAX = $clog2(MAX_SETS + 1) - 1;
  localparam int SET_W   = (IDX_MAX > 0) ? IDX_MAX : 1;
  localparam int ROWS    = 1 << SET_W;
  localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  logic [CFG_W-1:0] set_bits;
  logic [CFG_W-1:0] ways;

  logic [BITS_W-1:0] bits_eff;
  logic [WCNT_W-1:0] ways_eff;
  logic [SET_W-1:0]  set_in;
  logic [TAG_W-1:0]  tag_in;
  logic [SET_W-1:0]  set_q;
  logic [TAG_W-1:0]  tag_q;
  logic [SET_W-1:0]  clr_cnt;

  line_t [MAX_WAYS-1:0] mem [ROWS];
  line_t [MAX_WAYS-1:0] row_q;
  line_t [MAX_WAYS-1:0] row_new;
  line_t [MAX_WAYS-1:0] row_wr;
  logic  [SET_W-1:0]    wr_addr;

  logic [MAX_WAYS-1:0] in_use;
  logic [MAX_WAYS-1:0] match;
  logic [MAX_WAYS-1:0] free;
  logic [MAX_WAYS-1:0] aged;
  logic [MAX_WAYS-1:0] oldest;
  logic [WAY_W-1:0]    hit_way;
  logic [WAY_W-1:0]    free_way;
  logic [WAY_W-1:0]    aged_way;
  logic [WAY_W-1:0]    old_way;
  logic [WAY_W-1:0]    victim;
  logic [AGE_W-1:0]    target;
  logic                hit;
  logic                placed;
  logic                found;

  logic [CNT_W-1:0] hits;
  logic [CNT_W-1:0] misses;
  logic [CNT_W-1:0] hits_next;
  logic [CNT_W-1:0] misses_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits <= SET_BITS_RESET;
      ways     <= WAYS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SET_BITS: set_bits <= cfg_data;
        REG_WAYS:     ways     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if ({1'b0, set_bits} > BITS_W'(IDX_MAX)) begin
      bits_eff = BITS_W'(IDX_MAX);
    end else begin
      bits_eff = {1'b0, set_bits};
    end
    if (ways == '0) begin
      ways_eff = WCNT_W'(1);
    end else if ({1'b0, ways} > WCNT_W'(MAX_WAYS)) begin
      ways_eff = WCNT_W'(MAX_WAYS);
    end else begin
      ways_eff = {1'b0, ways};
    end
    for (int k = 0; k < SET_W; k++) begin
      set_in[k] = s_axis_tdata[k] && (BITS_W'(k) < bits_eff);
    end
    tag_in = s_axis_tdata >> bits_eff;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      set_q <= set_in;
      tag_q <= tag_in;
      row_q <= mem[set_in];
    end
  end

  assign wr_addr = cmd.clear ? clr_cnt : set_q;
  assign row_wr  = cmd.clear ? '0 : row_new;

  always_ff @(posedge clk) begin
    if (cmd.clear || cmd.commit) begin
      mem[wr_addr] <= row_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + SET_W'(1);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      in_use[i] = WCNT_W'(i) < ways_eff;
      match[i]  = in_use[i] && row_q[i].valid && (row_q[i].tag == tag_q);
      free[i]   = in_use[i] && !row_q[i].valid;
      aged[i]   = in_use[i] && ({1'b0, row_q[i].age} == ways_eff);
      oldest[i] = in_use[i];
      for (int j = 0; j < MAX_WAYS; j++) begin
        if ((WCNT_W'(j) < ways_eff) && (row_q[j].age > row_q[i].age)) begin
          oldest[i] = 1'b0;
        end
      end
    end
    hit_way  = '0;
    free_way = '0;
    aged_way = '0;
    old_way  = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_way = WAY_W'(i);
      end
      if (free[i]) begin
        free_way = WAY_W'(i);
      end
      if (aged[i]) begin
        aged_way = WAY_W'(i);
      end
      if (oldest[i]) begin
        old_way = WAY_W'(i);
      end
    end
    hit    = |match;
    placed = |free;
    found  = |aged;
    if (hit) begin
      victim = hit_way;
    end else if (placed) begin
      victim = free_way;
    end else if (found) begin
      victim = aged_way;
    end else begin
      victim = old_way;
    end
    target  = row_q[victim].age;
    row_new = row_q;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (in_use[i] && row_q[i].valid && (WAY_W'(i) != victim)) begin
        if (hit || !placed) begin
          if (row_q[i].age < target) begin
            row_new[i].age = age_inc(row_q[i].age);
          end
        end else if (row_q[i].age != '0) begin
          row_new[i].age = age_inc(row_q[i].age);
        end
      end
    end
    if (!hit) begin
      row_new[victim].valid = 1'b1;
      row_new[victim].tag   = tag_q;
    end
    row_new[victim].age = AGE_MRU;
  end

  assign hits_next   = hit ? hits + CNT_W'(1) : hits;
  assign misses_next = hit ? misses : misses + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      hits   <= '0;
      misses <= '0;
    end else if (cmd.commit) begin
      hits   <= hits_next;
      misses <= misses_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_axis_tuser <= hit;
      m_axis_tdata <= {(OUT_DATA_W - OUT_USED_W)'(0), misses_next, hits_next,
                       SET_OUT_W'(set_q), WAY_OUT_W'(victim)};
    end
  end

  assign status.clear_last = &clr_cnt;
  assign status.out_free   = !m_axis_tvalid || m_axis_tready;

endmodule

`default_nettype wire
